// ----- rtl/two_d_histogram_binner_assert.svh -----
// Assertion helpers for the two-dimensional histogram binner.
`ifndef TWO_D_HISTOGRAM_BINNER_ASSERT_SVH
`define TWO_D_HISTOGRAM_BINNER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define TDHB_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("histogram binner check failed");

// Next-cycle implication, held off during reset.
`define TDHB_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("histogram binner check failed");

`endif

// ----- rtl/tdhb_pkg.sv -----
package tdhb_pkg;

  localparam int unsigned BINS_X_DEF = 512;
  localparam int unsigned BINS_Y_DEF = 512;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned BIN_W      = 9;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [SAMPLE_W-1:0] LOW_RESET  = 32'd0;
  localparam logic [SAMPLE_W-1:0] HIGH_RESET = 32'd65536;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_X  = 2'd0,
    CFG_HIGH_X = 2'd1,
    CFG_LOW_Y  = 2'd2,
    CFG_HIGH_Y = 2'd3
  } cfg_idx_e;

  typedef enum logic [7:0] {
    S_SWEEP = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_PREP  = 8'b0000_0100,
    S_DIV   = 8'b0000_1000,
    S_ADDR  = 8'b0001_0000,
    S_READ  = 8'b0010_0000,
    S_MOD   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_MUL  = 4'b0010,
    D_LOAD = 4'b0100,
    D_ITER = 4'b1000
  } div_state_e;

  typedef struct packed {
    logic [1:0]          mode;
    logic [SAMPLE_W-1:0] sample_x;
    logic [SAMPLE_W-1:0] sample_y;
    logic [BIN_W-1:0]    read_bin_x;
    logic [BIN_W-1:0]    read_bin_y;
  } in_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] bin_count;
    logic                  accepted;
    logic [BIN_W-1:0]      bin_x;
    logic [BIN_W-1:0]      bin_y;
  } out_t;

endpackage

// ----- rtl/tdhb_mem.sv -----
module tdhb_mem #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned AW    = 2,
  parameter int unsigned DW    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tdhb_div.sv -----
// Restoring divider: quot = floor(BINS * off / range), with off < range.
module tdhb_div #(
  parameter int unsigned BINS = 512,
  parameter int unsigned QW   = $clog2(BINS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [31:0]   off_i,
  input  logic [31:0]   range_i,
  output logic          busy_o,
  output logic [QW-1:0] quot_o
);

  localparam int unsigned PW = 32 + QW;
  localparam int unsigned CW = $clog2(QW + 1);

  tdhb_pkg::div_state_e state_q, state_d;
  logic [PW-1:0] prod_q;
  logic [31:0]   rem_q;
  logic [QW-1:0] lo_q;
  logic [QW-1:0] quot_q;
  logic [CW-1:0] cnt_q;
  logic [32:0]   trial;
  logic          fits;

  // One quotient bit per step: shift in the next product bit, try to subtract.
  assign trial = {rem_q, lo_q[QW-1]};
  assign fits  = trial >= {1'b0, range_i};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tdhb_pkg::D_IDLE: if (start_i) state_d = tdhb_pkg::D_MUL;
      tdhb_pkg::D_MUL:  state_d = tdhb_pkg::D_LOAD;
      tdhb_pkg::D_LOAD: state_d = tdhb_pkg::D_ITER;
      tdhb_pkg::D_ITER: if (cnt_q == CW'(1)) state_d = tdhb_pkg::D_IDLE;
      default:          state_d = tdhb_pkg::D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tdhb_pkg::D_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == tdhb_pkg::D_LOAD) begin
        cnt_q <= CW'(QW);
      end else if (state_q == tdhb_pkg::D_ITER) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      tdhb_pkg::D_MUL: begin
        prod_q <= PW'(off_i) * PW'(BINS);
      end
      tdhb_pkg::D_LOAD: begin
        rem_q  <= prod_q[PW-1:QW];
        lo_q   <= prod_q[QW-1:0];
        quot_q <= '0;
      end
      tdhb_pkg::D_ITER: begin
        rem_q  <= fits ? 32'(trial - {1'b0, range_i}) : trial[31:0];
        lo_q   <= lo_q << 1;
        quot_q <= (quot_q << 1) | QW'(fits);
      end
      default: begin
      end
    endcase
  end

  assign busy_o = state_q != tdhb_pkg::D_IDLE;
  assign quot_o = quot_q;

endmodule

// ----- rtl/two_d_histogram_binner.sv -----
// Two-dimensional histogram of signed 32-bit (x,y) samples.
// Input channel in_valid_i/in_stall_o carries one word per item: a mode
// (clear all bins, add a sample, read one bin) and its operands. The output
// channel out_valid_o/out_stall_i returns exactly one word per item.
// The configuration channel (cfg_valid_i/cfg_ready_o, index and data) sets
// the low/high edges of each axis; write it only while the block is idle.
// Items are handled one at a time. An added sample that falls in range takes
// one bit-serial quotient step per bin bit on each axis (both axes run in
// parallel), then a read-modify-write of the count memory, before its result
// word shows. A read of a valid bin fetches its count from the memory; a
// rejected sample or an unused mode answers without touching the memory. The
// next word can be taken in the cycle that the result word shows. Clearing
// sweeps the memory one entry per cycle over all BINS_X*BINS_Y entries (262144
// at the default size) and then answers.
// After reset the same sweep runs with in_stall_o high and no result word.
// The result sits in an output register, so a stalled receiver only holds
// back the next item once it is finished; the word stays steady while stalled.
module two_d_histogram_binner #(
  parameter int unsigned BINS_X = tdhb_pkg::BINS_X_DEF,
  parameter int unsigned BINS_Y = tdhb_pkg::BINS_Y_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  tdhb_pkg::in_t                       in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output tdhb_pkg::out_t                      out_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tdhb_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tdhb_pkg::SAMPLE_W-1:0]       cfg_data_i
);

  localparam int unsigned XW    = $clog2(BINS_X);
  localparam int unsigned YW    = $clog2(BINS_Y);
  localparam int unsigned DEPTH = BINS_X * BINS_Y;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CB    = tdhb_pkg::COUNT_BITS;
  localparam int unsigned BW    = tdhb_pkg::BIN_W;

  // Control state.
  tdhb_pkg::state_e state_q, state_d;
  logic [AW-1:0]    clr_cnt_q;
  logic             reply_q;
  logic             out_valid_q;

  // Configuration.
  logic [31:0] low_x_q, high_x_q, low_y_q, high_y_q;

  // Payload.
  tdhb_pkg::in_t  item_q;
  tdhb_pkg::out_t res_q, out_q;
  logic [31:0]    off_x_q, range_x_q, off_y_q, range_y_q;
  logic [XW-1:0]  bx_q;
  logic [YW-1:0]  by_q;
  logic [AW-1:0]  addr_q;

  // Datapath nets.
  tdhb_pkg::mode_e mode;
  logic            in_acc;
  logic            out_load;
  logic            ok_x, ok_y;
  logic            rd_ok;
  logic            div_start;
  logic            busy_x, busy_y;
  logic [XW-1:0]   quot_x;
  logic [YW-1:0]   quot_y;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [CB-1:0]   mem_wdata;
  logic            mem_re;
  logic [CB-1:0]   mem_rdata;
  logic [CB-1:0]   count_inc;

  assign mode   = tdhb_pkg::mode_e'(item_q.mode);
  assign in_acc = in_valid_i && !in_stall_o;

  // Range checks: empty or inverted range rejects, as does v outside [low, high).
  assign ok_x = ($signed(high_x_q) > $signed(low_x_q)) &&
                ($signed(item_q.sample_x) >= $signed(low_x_q)) &&
                ($signed(item_q.sample_x) < $signed(high_x_q));
  assign ok_y = ($signed(high_y_q) > $signed(low_y_q)) &&
                ($signed(item_q.sample_y) >= $signed(low_y_q)) &&
                ($signed(item_q.sample_y) < $signed(high_y_q));
  assign rd_ok = (32'(item_q.read_bin_x) < 32'(BINS_X)) &&
                 (32'(item_q.read_bin_y) < 32'(BINS_Y));

  assign div_start = (state_q == tdhb_pkg::S_PREP) && (mode == tdhb_pkg::MODE_ADD) &&
                     ok_x && ok_y;

  // Hand the result over only when the output register is free or draining.
  assign out_load = (state_q == tdhb_pkg::S_DONE) && (!out_valid_q || !out_stall_i);

  // Saturating increment of the fetched count.
  assign count_inc = (mem_rdata == {CB{1'b1}}) ? mem_rdata : mem_rdata + CB'(1);

  // Single write port: clearing sweep or the write-back of an added sample.
  assign mem_we    = (state_q == tdhb_pkg::S_SWEEP) ||
                     ((state_q == tdhb_pkg::S_MOD) && (mode == tdhb_pkg::MODE_ADD));
  assign mem_waddr = (state_q == tdhb_pkg::S_SWEEP) ? clr_cnt_q : addr_q;
  assign mem_wdata = (state_q == tdhb_pkg::S_SWEEP) ? '0 : count_inc;
  assign mem_re    = state_q == tdhb_pkg::S_READ;

  tdhb_div #(
    .BINS (BINS_X),
    .QW   (XW)
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .off_i   (off_x_q),
    .range_i (range_x_q),
    .busy_o  (busy_x),
    .quot_o  (quot_x)
  );

  tdhb_div #(
    .BINS (BINS_Y),
    .QW   (YW)
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .off_i   (off_y_q),
    .range_i (range_y_q),
    .busy_o  (busy_y),
    .quot_o  (quot_y)
  );

  tdhb_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (CB)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (addr_q),
    .rdata_o (mem_rdata)
  );

  // Sequencer. Each item runs to completion before the next is taken, so a
  // write-back always lands before the following read of the same entry.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tdhb_pkg::S_SWEEP: begin
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          state_d = reply_q ? tdhb_pkg::S_DONE : tdhb_pkg::S_IDLE;
        end
      end
      tdhb_pkg::S_IDLE: begin
        if (in_valid_i) state_d = tdhb_pkg::S_PREP;
      end
      tdhb_pkg::S_PREP: begin
        unique case (mode)
          tdhb_pkg::MODE_CLEAR: state_d = tdhb_pkg::S_SWEEP;
          tdhb_pkg::MODE_ADD:   state_d = (ok_x && ok_y) ? tdhb_pkg::S_DIV : tdhb_pkg::S_DONE;
          tdhb_pkg::MODE_READ:  state_d = rd_ok ? tdhb_pkg::S_ADDR : tdhb_pkg::S_DONE;
          tdhb_pkg::MODE_NONE:  state_d = tdhb_pkg::S_DONE;
        endcase
      end
      tdhb_pkg::S_DIV: begin
        if (!busy_x && !busy_y) state_d = tdhb_pkg::S_ADDR;
      end
      tdhb_pkg::S_ADDR: state_d = tdhb_pkg::S_READ;
      tdhb_pkg::S_READ: state_d = tdhb_pkg::S_MOD;
      tdhb_pkg::S_MOD:  state_d = tdhb_pkg::S_DONE;
      tdhb_pkg::S_DONE: begin
        if (out_load) state_d = tdhb_pkg::S_IDLE;
      end
      default: state_d = tdhb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdhb_pkg::S_SWEEP;
      clr_cnt_q   <= '0;
      reply_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == tdhb_pkg::S_SWEEP) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end else begin
        clr_cnt_q <= '0;
      end
      // Only a clear command answers at the end of its sweep.
      if ((state_q == tdhb_pkg::S_PREP) && (mode == tdhb_pkg::MODE_CLEAR)) begin
        reply_q <= 1'b1;
      end else if (state_q == tdhb_pkg::S_DONE) begin
        reply_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Configuration registers; the port never pushes back.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_x_q  <= tdhb_pkg::LOW_RESET;
      high_x_q <= tdhb_pkg::HIGH_RESET;
      low_y_q  <= tdhb_pkg::LOW_RESET;
      high_y_q <= tdhb_pkg::HIGH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (tdhb_pkg::cfg_idx_e'(cfg_index_i))
        tdhb_pkg::CFG_LOW_X:  low_x_q  <= cfg_data_i;
        tdhb_pkg::CFG_HIGH_X: high_x_q <= cfg_data_i;
        tdhb_pkg::CFG_LOW_Y:  low_y_q  <= cfg_data_i;
        tdhb_pkg::CFG_HIGH_Y: high_y_q <= cfg_data_i;
      endcase
    end
  end

  // Payload path.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_i;
    end
    unique case (state_q)
      tdhb_pkg::S_PREP: begin
        // Offsets and spans wrap mod 2^32; they are only used when in range.
        off_x_q   <= item_q.sample_x - low_x_q;
        range_x_q <= high_x_q - low_x_q;
        off_y_q   <= item_q.sample_y - low_y_q;
        range_y_q <= high_y_q - low_y_q;
        bx_q      <= XW'(item_q.read_bin_x);
        by_q      <= YW'(item_q.read_bin_y);
        res_q.bin_count <= '0;
        res_q.accepted  <= 1'b0;
        // Out-of-range read echoes the requested indices.
        res_q.bin_x <= (mode == tdhb_pkg::MODE_READ) ? item_q.read_bin_x : '0;
        res_q.bin_y <= (mode == tdhb_pkg::MODE_READ) ? item_q.read_bin_y : '0;
      end
      tdhb_pkg::S_DIV: begin
        bx_q <= quot_x;
        by_q <= quot_y;
      end
      tdhb_pkg::S_ADDR: begin
        addr_q <= AW'(AW'(by_q) * AW'(BINS_Y > 0 ? BINS_X : 1)) + AW'(bx_q);
      end
      tdhb_pkg::S_MOD: begin
        res_q.bin_count <= (mode == tdhb_pkg::MODE_ADD) ? count_inc : mem_rdata;
        res_q.accepted  <= 1'b1;
        res_q.bin_x     <= BW'(bx_q);
        res_q.bin_y     <= BW'(by_q);
      end
      tdhb_pkg::S_SWEEP: begin
        res_q <= '0;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign in_stall_o  = state_q != tdhb_pkg::S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `include "two_d_histogram_binner_assert.svh"

  // An accepted word always moves the sequencer into operand preparation.
  `TDHB_ASSERT_NEXT(a_accept_prep, clk_i, rst_ni, in_acc, state_q == tdhb_pkg::S_PREP)

  // The count memory is written only by the sweep or by a sample write-back.
  `TDHB_ASSERT_NOW(a_mem_write_src, clk_i, rst_ni, mem_we, (state_q == tdhb_pkg::S_SWEEP) || (state_q == tdhb_pkg::S_MOD))

  // A rejected or invalid result never carries a count.
  `TDHB_ASSERT_NOW(a_reject_zero, clk_i, rst_ni, out_valid_o && !out_o.accepted, out_o.bin_count == '0)

endmodule
